// ===== design/lzwcsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwcsw_pkg
// Shared constants, codes and types of the LZW code stream walker.
// ----------------------------------------------------------------------------
package lzwcsw_pkg;

   // code width range
   localparam int MIN_CODE_BITS = 9;
   localparam int MAX_CODE_BITS = 12;
   localparam int BYTE_BITS     = 8;

   // derived storage widths
   localparam int BUF_W  = MAX_CODE_BITS - 1 + BYTE_BITS;
   localparam int CNT_W  = $clog2(BUF_W + 1);
   localparam int CODE_W = MAX_CODE_BITS;

   // fixed field widths
   localparam int WID_W   = 4;
   localparam int NFC_W   = 13;
   localparam int CNT16_W = 16;
   localparam int BITS_W  = 19;
   localparam int CMP_W   = (CODE_W > NFC_W) ? CODE_W : NFC_W;

   // special codes
   localparam logic [NFC_W-1:0] CODE_CLEAR = NFC_W'(256);
   localparam logic [NFC_W-1:0] CODE_END   = NFC_W'(257);
   localparam logic [NFC_W-1:0] CODE_FIRST = NFC_W'(258);
   localparam logic [NFC_W-1:0] DICT_LIMIT = NFC_W'(4096);

   // verdicts
   localparam logic [1:0] VERDICT_CLEAN = 2'd0;
   localparam logic [1:0] VERDICT_TRUNC = 2'd1;
   localparam logic [1:0] VERDICT_EMPTY = 2'd2;

   typedef struct packed {
      logic [BUF_W-1:0]   bit_buf;
      logic [CNT_W-1:0]   buf_cnt;
      logic [WID_W-1:0]   code_width;
      logic [NFC_W-1:0]   free_code;
      logic [CNT16_W-1:0] codes;
      logic [BITS_W-1:0]  bits;
      logic [CNT16_W-1:0] clears;
      logic [CNT16_W-1:0] growths;
      logic [NFC_W-1:0]   peak;
      logic               reserved;
      logic               full;
      logic               finished;
   } walk_state_type;

   typedef struct packed {
      logic               valid;
      logic [CODE_W-1:0]  code;
      logic [BUF_W-1:0]   rest_buf;
      logic [CNT_W-1:0]   rest_cnt;
   } code_slice_type;

endpackage

// ===== design/lzw_code_stream_walker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_code_stream_walker_unit
// Walks the LSB-first 9..12 bit LZW code stream of one entry and reports one
// summary transaction per entry.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  req_    | in        | tdata = compressed byte, tlast = last byte, tuser = empty entry
//  rsp_    | out       | tuser = verdict, tdata = counters and flags of the entry
//
//  One byte per cycle while the result register is free or being taken: a byte
//  is held in the input register, unpacked and applied to the walk state, and its
//  summary (if any) lands in the result register, which drives rsp_tvalid.
//  Reset is synchronous and returns the walk state to a fresh entry.
//  A stalled rsp_ holds the result register; the input register still takes
//  one more byte, then req_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module lzw_code_stream_walker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic        req_tuser,   // empty_entry
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // code_total[15:0], bit_total[34:16],
                                    // final_code_width[38:35], peak_free_code[51:39],
                                    // clear_count[67:52], width_growths[83:68],
                                    // reserved_seen[84], dictionary_full[85], zero pad
   output logic [1:0]  rsp_tuser    // verdict
);
   import lzwcsw_pkg::*;

   // fresh-entry walk state
   function automatic walk_state_type clear_state();
      walk_state_type s;
      s            = '0;
      s.code_width = WID_W'(MIN_CODE_BITS);
      s.free_code  = CODE_FIRST;
      return s;
   endfunction

   // input register
   logic           s1_valid_ff, s1_valid_in;
   logic [7:0]     s1_data_ff;
   logic           s1_last_ff;
   logic           s1_empty_ff;

   // walk state
   walk_state_type st_ff, st_in;

   // result register
   logic           out_valid_ff, out_valid_in;
   logic [1:0]     out_verdict_ff;
   walk_state_type out_res_ff;

   logic           advance;
   logic           emit;
   logic [1:0]     verdict;
   walk_state_type res_st;
   walk_state_type merged_st;
   walk_state_type dict_st;
   code_slice_type slice;
   logic           is_end;

   // the byte in the input register is processed as soon as the result slot is free
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   lzwcsw_unpack u_unpack (
      .bit_buf    (st_ff.bit_buf),
      .buf_cnt    (st_ff.buf_cnt),
      .code_width (st_ff.code_width),
      .data_byte  (s1_data_ff),
      .slice      (slice)
   );

   // state with the byte merged and the code (if complete) removed
   always_comb begin
      merged_st         = st_ff;
      merged_st.bit_buf = slice.rest_buf;
      merged_st.buf_cnt = slice.rest_cnt;
   end

   lzwcsw_dict_track u_dict (
      .cur    (merged_st),
      .code   (slice.code),
      .nxt    (dict_st),
      .is_end (is_end)
   );

   // decide next walk state and whether this byte closes the entry
   always_comb begin
      st_in   = st_ff;
      emit    = 1'b0;
      verdict = VERDICT_CLEAN;
      res_st  = dict_st;
      if (advance) begin
         if (s1_empty_ff) begin
            // empty entry wins over everything
            st_in   = clear_state();
            emit    = 1'b1;
            verdict = VERDICT_EMPTY;
            res_st  = clear_state();
         end else if (st_ff.finished) begin
            // drop bytes after the end code until the last one
            if (s1_last_ff) begin
               st_in = clear_state();
            end
         end else if (slice.valid && is_end) begin
            emit    = 1'b1;
            verdict = VERDICT_CLEAN;
            if (s1_last_ff) begin
               st_in = clear_state();
            end else begin
               st_in          = dict_st;
               st_in.bit_buf  = '0;
               st_in.buf_cnt  = '0;
               st_in.finished = 1'b1;
            end
         end else begin
            res_st = slice.valid ? dict_st : merged_st;
            if (s1_last_ff) begin
               // partial code is dropped, only complete codes are counted
               emit    = 1'b1;
               verdict = VERDICT_TRUNC;
               st_in   = clear_state();
            end else begin
               st_in = res_st;
            end
         end
      end
   end

   always_comb begin
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (advance && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         st_ff        <= clear_state();
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         st_ff        <= st_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff  <= req_tdata;
         s1_last_ff  <= req_tlast;
         s1_empty_ff <= req_tuser;
      end
      if (advance && emit) begin
         out_verdict_ff <= verdict;
         out_res_ff     <= res_st;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_verdict_ff;
   assign rsp_tdata  = {2'b00,
                        out_res_ff.full,
                        out_res_ff.reserved,
                        out_res_ff.growths,
                        out_res_ff.clears,
                        out_res_ff.peak,
                        out_res_ff.code_width,
                        out_res_ff.bits,
                        out_res_ff.codes};

`ifndef SYNTHESIS
   // leftover bits never reach a full code
   a_buf_below_width: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(st_ff.code_width) > st_ff.buf_cnt)
      else $error("bit buffer holds a complete code");

   // width stays in its range
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff.code_width >= WID_W'(MIN_CODE_BITS)) &&
      (st_ff.code_width <= WID_W'(MAX_CODE_BITS)))
      else $error("code width out of range");

   // a finished entry keeps an empty bit buffer
   a_finished_empty: assert property (@(posedge clock) disable iff (reset)
      st_ff.finished |-> (st_ff.buf_cnt == '0))
      else $error("bits left after end code");

   // next free code never runs past one above the limit
   a_free_code_cap: assert property (@(posedge clock) disable iff (reset)
      st_ff.free_code <= DICT_LIMIT + NFC_W'(1))
      else $error("next free code beyond limit");

   // an empty input register always takes a byte
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input register empty but not ready");
`endif

endmodule

// ===== design/lzwcsw_unpack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwcsw_unpack
// Merge one byte into the bit buffer and cut off the next code, LSB first.
// ----------------------------------------------------------------------------
module lzwcsw_unpack (
   input  logic [lzwcsw_pkg::BUF_W-1:0]  bit_buf,
   input  logic [lzwcsw_pkg::CNT_W-1:0]  buf_cnt,
   input  logic [lzwcsw_pkg::WID_W-1:0]  code_width,
   input  logic [7:0]                    data_byte,
   output lzwcsw_pkg::code_slice_type    slice
);
   import lzwcsw_pkg::*;

   logic [BUF_W-1:0]  merged;
   logic [CNT_W-1:0]  merged_cnt;
   logic [CNT_W-1:0]  width_ext;
   logic [CODE_W-1:0] mask;

   assign merged     = bit_buf | (BUF_W'(data_byte) << buf_cnt);
   assign merged_cnt = buf_cnt + CNT_W'(BYTE_BITS);
   assign width_ext  = CNT_W'(code_width);
   assign mask       = ~({CODE_W{1'b1}} << code_width);

   // a byte never completes more than one code: leftover stays below eight bits
   always_comb begin
      slice.valid = (merged_cnt >= width_ext);
      slice.code  = merged[CODE_W-1:0] & mask;
      if (slice.valid) begin
         slice.rest_buf = merged >> code_width;
         slice.rest_cnt = merged_cnt - width_ext;
      end else begin
         slice.rest_buf = merged;
         slice.rest_cnt = merged_cnt;
      end
   end

endmodule

// ===== design/lzwcsw_dict_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwcsw_dict_track
// Apply one complete code to the dictionary bookkeeping and counters.
// ----------------------------------------------------------------------------
module lzwcsw_dict_track (
   input  lzwcsw_pkg::walk_state_type      cur,
   input  logic [lzwcsw_pkg::CODE_W-1:0]   code,
   output lzwcsw_pkg::walk_state_type      nxt,
   output logic                            is_end
);
   import lzwcsw_pkg::*;

   logic [CMP_W-1:0]  code_ext;
   logic [BITS_W:0]   bits_sum;
   logic [NFC_W-1:0]  next_inc;
   logic [NFC_W-1:0]  next_hi;

   assign code_ext = CMP_W'(code);
   assign bits_sum = {1'b0, cur.bits} + (BITS_W + 1)'(cur.code_width);
   assign next_inc = cur.free_code + NFC_W'(1);
   assign next_hi  = next_inc >> cur.code_width;

   always_comb begin
      nxt    = cur;
      is_end = 1'b0;
      if (cur.codes != '1) begin
         nxt.codes = cur.codes + CNT16_W'(1);
      end
      // saturate on carry out
      nxt.bits = bits_sum[BITS_W] ? '1 : bits_sum[BITS_W-1:0];

      if (code_ext == CMP_W'(CODE_CLEAR)) begin
         if (cur.clears != '1) begin
            nxt.clears = cur.clears + CNT16_W'(1);
         end
         nxt.free_code  = CODE_FIRST;
         nxt.code_width = WID_W'(MIN_CODE_BITS);
      end else if (code_ext == CMP_W'(CODE_END)) begin
         is_end = 1'b1;
      end else begin
         if (code_ext >= CMP_W'(cur.free_code)) begin
            nxt.reserved = 1'b1;
         end
         if (cur.free_code > cur.peak) begin
            nxt.peak = cur.free_code;
         end
         if (cur.free_code > DICT_LIMIT) begin
            nxt.full = 1'b1;
         end else begin
            nxt.free_code = next_inc;
            if ((next_hi != '0) && (cur.code_width < WID_W'(MAX_CODE_BITS))) begin
               if (cur.growths != '1) begin
                  nxt.growths = cur.growths + CNT16_W'(1);
               end
               nxt.code_width = cur.code_width + WID_W'(1);
            end else if (next_inc > DICT_LIMIT) begin
               nxt.full = 1'b1;
            end
         end
      end
   end

endmodule

// ===== tb/lzw_code_stream_walker_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_code_stream_walker_unit_tb
// Drives compressed entries into the code stream walker and checks every
// per-entry summary against a bit-true walk of the same byte stream or, for
// typed rows, a hand-written one. A short table of hand-built entries runs first;
// random entries packed from code sequences, noise bytes and empty entries follow.
// ----------------------------------------------------------------------------
module lzw_code_stream_walker_unit_tb;
   import lzwcsw_pkg::*;

   localparam int IDLE_PCT     = 38;     // chance of a gap on either side
   localparam int RANDOM_ITEMS = 1700;   // short random bytes to generate
   localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
   localparam int STALL_LIMIT  = 2000;   // cycles without any transaction
   localparam int DRAIN_CYCLES = 8;      // settle time after the last summary
   localparam int CNT16_MAX    = 65535;
   localparam int BITS_MAX     = 524287;
   localparam int PLAN_ROWS    = 19;

   // one entry summary, as carried by rsp_tuser / rsp_tdata
   typedef struct packed {
      logic [1:0]         verdict;
      logic [CNT16_W-1:0] codes;
      logic [BITS_W-1:0]  bits;
      logic [WID_W-1:0]   width;
      logic [NFC_W-1:0]   peak;
      logic [CNT16_W-1:0] clears;
      logic [CNT16_W-1:0] growths;
      logic               reserved;
      logic               full;
   } summary_type;

   // one byte transaction; typed rows carry a hand-written summary
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        empty;
      logic        typed;
      summary_type want;
   } byte_item_type;

   // row of the opening table; summaries that can be read at a glance only
   typedef struct packed {
      logic [7:0]         data;
      logic               last;
      logic               empty;
      logic               typed;
      logic [1:0]         verdict;
      logic [CNT16_W-1:0] codes;
      logic [BITS_W-1:0]  bits;
      logic [CNT16_W-1:0] clears;
   } plan_row_type;

   // Opening table:
   //  - empty entry at start, single byte truncated, empty wins over last
   //  - end code alone (0x101 in 9 bits), trailing bytes ignored until last
   //  - clear then end code closed on the last byte
   //  - all-ones codes above the next free code, truncated
   //  - empty entry abandoning a half-walked entry, then zero codes truncated
   plan_row_type opening_plan [PLAN_ROWS] = '{
      '{8'hFF, 1'b0, 1'b1, 1'b1, VERDICT_EMPTY, 16'd0, 19'd0,  16'd0},
      '{8'h00, 1'b1, 1'b0, 1'b1, VERDICT_TRUNC, 16'd0, 19'd0,  16'd0},
      '{8'hA5, 1'b1, 1'b1, 1'b1, VERDICT_EMPTY, 16'd0, 19'd0,  16'd0},
      '{8'h01, 1'b0, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'h01, 1'b0, 1'b0, 1'b1, VERDICT_CLEAN, 16'd1, 19'd9,  16'd0},
      '{8'hAA, 1'b0, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'h55, 1'b1, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'h03, 1'b0, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'h02, 1'b1, 1'b0, 1'b1, VERDICT_CLEAN, 16'd2, 19'd18, 16'd1},
      '{8'hFF, 1'b0, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'h00, 1'b1, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'h00, 1'b0, 1'b1, 1'b1, VERDICT_EMPTY, 16'd0, 19'd0,  16'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0},
      '{8'h00, 1'b1, 1'b0, 1'b0, VERDICT_CLEAN, 16'd0, 19'd0,  16'd0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // last_byte
   logic        req_tuser;   // empty_entry
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;   // code_total[15:0], bit_total[34:16],
                             // final_code_width[38:35], peak_free_code[51:39],
                             // clear_count[67:52], width_growths[83:68],
                             // reserved_seen[84], dictionary_full[85], zero pad
   logic [1:0]  rsp_tuser;   // verdict

   byte_item_type byte_stream[$];         // bytes still to be offered, in order
   summary_type   expected_summaries[$];  // summaries owed by the block

   // state of the reference walk
   int unsigned walk_buf;
   int unsigned walk_nbits;
   int unsigned walk_width;
   int unsigned walk_next;
   int unsigned walk_codes;
   int unsigned walk_bits;
   int unsigned walk_clears;
   int unsigned walk_growths;
   int unsigned walk_peak;
   bit          walk_reserved;
   bit          walk_full;
   bit          walk_done;

   // run bookkeeping
   int  mismatches;
   int  bytes_taken;
   int  summaries_seen;
   int  clean_seen;
   int  trunc_seen;
   int  empty_seen;
   int  full_seen;
   int  saturated_seen;
   bit  steady_now;

   lzw_code_stream_walker_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Return the walk to a fresh entry.
   function automatic void restart_entry();
      walk_buf      = 0;
      walk_nbits    = 0;
      walk_width    = MIN_CODE_BITS;
      walk_next     = CODE_FIRST;
      walk_codes    = 0;
      walk_bits     = 0;
      walk_clears   = 0;
      walk_growths  = 0;
      walk_peak     = 0;
      walk_reserved = 1'b0;
      walk_full     = 1'b0;
      walk_done     = 1'b0;
   endfunction

   function automatic summary_type walk_summary(input logic [1:0] verdict);
      summary_type s;
      s.verdict  = verdict;
      s.codes    = CNT16_W'(walk_codes);
      s.bits     = BITS_W'(walk_bits);
      s.width    = WID_W'(walk_width);
      s.peak     = NFC_W'(walk_peak);
      s.clears   = CNT16_W'(walk_clears);
      s.growths  = CNT16_W'(walk_growths);
      s.reserved = walk_reserved;
      s.full     = walk_full;
      return s;
   endfunction

   // Apply one accepted byte to the reference walk; report the summary it
   // closes, if any.
   task automatic walk_byte(input logic [7:0] data, input logic last, input logic empty,
                            output bit emitted, output summary_type s);
      int unsigned code;
      bit          ended;
      emitted = 1'b0;
      ended   = 1'b0;
      s       = '0;
      if (empty) begin
         // empty marker wins: drop whatever was half walked
         restart_entry();
         s       = walk_summary(VERDICT_EMPTY);
         emitted = 1'b1;
         return;
      end
      if (walk_done) begin
         // past the end code: only the last byte matters
         if (last) restart_entry();
         return;
      end
      walk_buf   = walk_buf | (32'(data) << walk_nbits);
      walk_nbits = walk_nbits + 8;
      while (!ended && walk_nbits >= walk_width) begin
         code       = walk_buf & ((32'd1 << walk_width) - 1);
         walk_buf   = walk_buf >> walk_width;
         walk_nbits = walk_nbits - walk_width;
         if (walk_codes < CNT16_MAX) walk_codes++;
         walk_bits = walk_bits + walk_width;
         if (walk_bits > BITS_MAX) walk_bits = BITS_MAX;
         if (code == CODE_CLEAR) begin
            if (walk_clears < CNT16_MAX) walk_clears++;
            walk_next  = CODE_FIRST;
            walk_width = MIN_CODE_BITS;
         end else if (code == CODE_END) begin
            ended = 1'b1;
         end else begin
            if (code >= walk_next) walk_reserved = 1'b1;
            if (walk_next > walk_peak) walk_peak = walk_next;
            if (walk_next > DICT_LIMIT) begin
               walk_full = 1'b1;
            end else begin
               walk_next++;
               if (walk_next > (32'd1 << walk_width) - 1 && walk_width < MAX_CODE_BITS) begin
                  if (walk_growths < CNT16_MAX) walk_growths++;
                  walk_width++;
               end else if (walk_next > DICT_LIMIT) begin
                  walk_full = 1'b1;
               end
            end
         end
      end
      if (ended) begin
         s       = walk_summary(VERDICT_CLEAN);
         emitted = 1'b1;
         if (last) begin
            restart_entry();
         end else begin
            // drop the rest of the byte and ignore bytes until the last one
            walk_buf   = 0;
            walk_nbits = 0;
            walk_done  = 1'b1;
         end
      end else if (last) begin
         s       = walk_summary(VERDICT_TRUNC);
         emitted = 1'b1;
         restart_entry();
      end
   endtask

   task automatic push_byte(input logic [7:0] data, input logic last, input logic empty);
      byte_item_type it;
      it       = '0;
      it.data  = data;
      it.last  = last;
      it.empty = empty;
      byte_stream.push_back(it);
   endtask

   // Pack a chosen code sequence LSB first into bytes of one entry. The width
   // follows the same growth and clear rules as the block so that every code
   // lands where the walker will look for it.
   task automatic build_entry(input int n_codes, input int clear_pct, input int clear_at,
                              input bit with_end, input int trailing);
      logic [7:0] bytes[$];
      bit [63:0]  acc;
      int         nb;
      int         width;
      int         next;
      int         code;
      int         top;
      int         n_total;
      acc     = '0;
      nb      = 0;
      width   = MIN_CODE_BITS;
      next    = CODE_FIRST;
      n_total = n_codes + (with_end ? 1 : 0);
      for (int i = 0; i < n_total; i++) begin
         top = (1 << width) - 1;
         if (i == n_codes) begin
            code = CODE_END;
         end else if (i == clear_at || $urandom_range(99) < clear_pct) begin
            code = CODE_CLEAR;
         end else if ($urandom_range(99) < 8 && next <= top) begin
            // at or above the next free code: flags reserved_seen
            code = $urandom_range(top, next);
         end else if (next > CODE_FIRST && $urandom_range(1) == 1) begin
            code = $urandom_range(CODE_FIRST, (next - 1 < top) ? next - 1 : top);
         end else begin
            code = $urandom_range(255);
         end
         acc = acc | (64'(code) << nb);
         nb  = nb + width;
         while (nb >= 8) begin
            bytes.push_back(acc[7:0]);
            acc = acc >> 8;
            nb  = nb - 8;
         end
         if (code == CODE_CLEAR) begin
            width = MIN_CODE_BITS;
            next  = CODE_FIRST;
         end else if (code != CODE_END && next <= DICT_LIMIT) begin
            next++;
            if (next > top && width < MAX_CODE_BITS) width++;
         end
      end
      // flush the partial byte, zero padded; a codeless entry still needs a byte
      if (nb > 0) bytes.push_back(acc[7:0]);
      else if (bytes.size() == 0) bytes.push_back(8'($urandom));
      for (int i = 0; i < trailing; i++) bytes.push_back(8'($urandom));
      foreach (bytes[i]) push_byte(bytes[i], i == bytes.size() - 1, 1'b0);
   endtask

   task automatic check_summary(input summary_type want, input summary_type got);
      if (got.verdict !== want.verdict) begin
         $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
         mismatches++;
      end
      if (got.codes !== want.codes) begin
         $error("code_total: expected %0d, got %0d", want.codes, got.codes);
         mismatches++;
      end
      if (got.bits !== want.bits) begin
         $error("bit_total: expected %0d, got %0d", want.bits, got.bits);
         mismatches++;
      end
      if (got.width !== want.width) begin
         $error("final_code_width: expected %0d, got %0d", want.width, got.width);
         mismatches++;
      end
      if (got.peak !== want.peak) begin
         $error("peak_free_code: expected %0d, got %0d", want.peak, got.peak);
         mismatches++;
      end
      if (got.clears !== want.clears) begin
         $error("clear_count: expected %0d, got %0d", want.clears, got.clears);
         mismatches++;
      end
      if (got.growths !== want.growths) begin
         $error("width_growths: expected %0d, got %0d", want.growths, got.growths);
         mismatches++;
      end
      if (got.reserved !== want.reserved) begin
         $error("reserved_seen: expected %0d, got %0d", want.reserved, got.reserved);
         mismatches++;
      end
      if (got.full !== want.full) begin
         $error("dictionary_full: expected %0d, got %0d", want.full, got.full);
         mismatches++;
      end
   endtask

   // Sample both channels at the rising edge: predict on every accepted byte,
   // compare every accepted summary with the oldest one owed.
   always @(posedge clock) begin : walk_monitor
      byte_item_type item;
      summary_type   predicted;
      summary_type   observed;
      bit            emitted;
      if (!reset && req_tvalid && req_tready) begin
         item = byte_stream.pop_front();
         bytes_taken++;
         walk_byte(req_tdata, req_tlast, req_tuser, emitted, predicted);
         // hand-written rows override the walk; only their summary is held to the block
         if (emitted) expected_summaries.push_back(item.typed ? item.want : predicted);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed.verdict  = rsp_tuser;
         observed.codes    = rsp_tdata[15:0];
         observed.bits     = rsp_tdata[34:16];
         observed.width    = rsp_tdata[38:35];
         observed.peak     = rsp_tdata[51:39];
         observed.clears   = rsp_tdata[67:52];
         observed.growths  = rsp_tdata[83:68];
         observed.reserved = rsp_tdata[84];
         observed.full     = rsp_tdata[85];
         summaries_seen++;
         if (observed.verdict == VERDICT_CLEAN) clean_seen++;
         if (observed.verdict == VERDICT_TRUNC) trunc_seen++;
         if (observed.verdict == VERDICT_EMPTY) empty_seen++;
         if (observed.full) full_seen++;
         if (observed.codes == CNT16_MAX) saturated_seen++;
         if (expected_summaries.size() == 0) begin
            $error("summary transaction with none pending: verdict %0d", observed.verdict);
            mismatches++;
         end else begin
            check_summary(expected_summaries.pop_front(), observed);
         end
      end
   end

   // Result side: random back-pressure, plus one long hold-off so the block
   // fills and stalls its input while the sender keeps offering bytes.
   initial begin : result_sink
      bit held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && summaries_seen >= 40) begin
            held       = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready = steady_now || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // End the run if neither channel moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      summary_type   want;
      byte_item_type it;
      int  short_items;
      int  mark;
      int  kind;
      int  n;
      int  sent;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      req_tlast          = 1'b0;
      req_tuser          = 1'b0;
      steady_now         = 1'b0;
      mismatches         = 0;
      bytes_taken        = 0;
      summaries_seen     = 0;
      clean_seen         = 0;
      trunc_seen         = 0;
      empty_seen         = 0;
      full_seen          = 0;
      saturated_seen     = 0;
      short_items        = 0;
      restart_entry();

      // opening table; typed summaries have base width and no flags
      foreach (opening_plan[r]) begin
         want         = '0;
         want.verdict = opening_plan[r].verdict;
         want.codes   = opening_plan[r].codes;
         want.bits    = opening_plan[r].bits;
         want.clears  = opening_plan[r].clears;
         want.width   = MIN_CODE_BITS;
         it.data      = opening_plan[r].data;
         it.last      = opening_plan[r].last;
         it.empty     = opening_plan[r].empty;
         it.typed     = opening_plan[r].typed;
         it.want      = want;
         byte_stream.push_back(it);
      end

      // random entries: mostly well-formed code sequences, the rest empty entries and noise
      while (short_items < RANDOM_ITEMS) begin
         mark = byte_stream.size();
         kind = $urandom_range(99);
         if (kind < 75) begin
            // long entries grow the width, then clear back to the base width
            if ($urandom_range(23) == 0) n = $urandom_range(400, 270);
            else n = $urandom_range(16);
            build_entry(n, 3, (n >= 270) ? $urandom_range(n - 1, 260) : -1, kind < 55,
                        (kind < 55 && $urandom_range(3) == 0) ? $urandom_range(3, 1) : 0);
         end else if (kind < 85) begin
            push_byte(8'($urandom), 1'($urandom), 1'b1);
         end else begin
            repeat ($urandom_range(12, 1))
               push_byte(8'($urandom), $urandom_range(5) == 0, $urandom_range(29) == 0);
         end
         short_items += byte_stream.size() - mark;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // offer bytes at the falling edge; hold each until it is taken
      sent = 0;
      while (byte_stream.size() != 0) begin
         steady_now = (sent >= 320 && sent < 720);
         while (!steady_now && $urandom_range(99) < IDLE_PCT) begin
            req_tvalid = 1'b0;
            req_tdata  = 8'($urandom);
            req_tlast  = 1'($urandom);
            req_tuser  = 1'($urandom);
            @(negedge clock);
         end
         req_tvalid = 1'b1;
         req_tdata  = byte_stream[0].data;
         req_tlast  = byte_stream[0].last;
         req_tuser  = byte_stream[0].empty;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sent++;
         @(negedge clock);
      end
      req_tvalid = 1'b0;
      steady_now = 1'b0;

      // drain: wait for every owed summary, then let the block settle
      while (expected_summaries.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Walked %0d bytes into %0d summaries: %0d clean, %0d truncated, %0d empty.",
               bytes_taken, summaries_seen, clean_seen, trunc_seen, empty_seen);
      $display("Full dictionary in %0d summaries, saturated counters in %0d; %0d mismatches.",
               full_seen, saturated_seen, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/lzwcsw_pkg.sv
design/lzwcsw_unpack.sv
design/lzwcsw_dict_track.sv
design/lzw_code_stream_walker_unit.sv
tb/lzw_code_stream_walker_unit_tb.sv
